@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dhcpx_pkg.sv @@
`timescale 1ns / 1ps

package dhcpx_pkg;

  // bytes of the options area that are examined per frame
  localparam int AREA_BYTES = 312;
  localparam int POS_W = $clog2(AREA_BYTES + 1);

  localparam logic [7:0] WANTED_RESET = 8'hFC;
  localparam logic [7:0] OPT_PAD = 8'h00;
  localparam logic [7:0] OPT_END = 8'hFF;

  localparam logic [7:0] MAGIC_COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_BADMAGIC = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_e;

  // one result produced by the option walker
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] vbyte;
    logic [7:0] vlen;
    logic       last;
  } dhcpx_res_t;

endpackage

@@ rtl/dhcpx_walk.sv @@
`timescale 1ns / 1ps

module dhcpx_walk
  import dhcpx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] opt_byte_i,
  input  logic       frame_last_i,
  input  logic [7:0] wanted_type_i,
  output dhcpx_res_t res_o
);

  typedef enum logic [2:0] {
    PH_MAGIC     = 3'd0,
    PH_TYPE      = 3'd1,
    PH_LEN_OTHER = 3'd2,
    PH_LEN_MATCH = 3'd3,
    PH_SKIP      = 3'd4,
    PH_VALUE     = 3'd5,
    PH_DONE      = 3'd6
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       magic_idx_q, magic_idx_d;
  logic             magic_ok_q, magic_ok_d;
  logic [7:0]       remain_q, remain_d;
  logic [7:0]       cur_len_q, cur_len_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             area_end;
  logic             ok_next;
  dhcpx_res_t       res;

  // next state and result for the byte on the input
  always_comb begin
    phase_d     = phase_q;
    magic_idx_d = magic_idx_q;
    magic_ok_d  = magic_ok_q;
    remain_d    = remain_q;
    cur_len_d   = cur_len_q;
    pos_d       = pos_q;
    res         = '0;
    area_end    = pos_q >= POS_W'(AREA_BYTES - 1);
    ok_next     = magic_ok_q & (opt_byte_i == MAGIC_COOKIE[magic_idx_q]);

    if (phase_q != PH_DONE && pos_q < POS_W'(AREA_BYTES)) begin
      case (phase_q)
        PH_MAGIC: begin
          magic_ok_d = ok_next;
          if (magic_idx_q == 2'd3) begin
            magic_idx_d = 2'd0;
            if (!ok_next) begin
              res.valid = 1'b1;
              res.kind  = KIND_BADMAGIC;
              res.last  = 1'b1;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_TYPE;
            end
          end else begin
            magic_idx_d = magic_idx_q + 2'd1;
          end
        end
        PH_TYPE: begin
          if (opt_byte_i == OPT_END) begin
            res.valid = 1'b1;
            res.kind  = KIND_NOTFOUND;
            res.last  = 1'b1;
            phase_d   = PH_DONE;
          end else if (opt_byte_i != OPT_PAD) begin
            phase_d = (opt_byte_i == wanted_type_i) ? PH_LEN_MATCH : PH_LEN_OTHER;
          end
        end
        PH_LEN_OTHER: begin
          remain_d = opt_byte_i;
          phase_d  = (opt_byte_i != 8'd0) ? PH_SKIP : PH_TYPE;
        end
        PH_LEN_MATCH: begin
          cur_len_d = opt_byte_i;
          if (opt_byte_i == 8'd0) begin
            res.valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
            phase_d   = PH_DONE;
          end else begin
            remain_d = opt_byte_i;
            phase_d  = PH_VALUE;
          end
        end
        PH_SKIP: begin
          remain_d = remain_q - 8'd1;
          if (remain_q == 8'd1) begin
            phase_d = PH_TYPE;
          end
        end
        PH_VALUE: begin
          remain_d  = remain_q - 8'd1;
          res.valid = 1'b1;
          res.kind  = KIND_VALUE;
          res.vbyte = opt_byte_i;
          res.vlen  = cur_len_q;
          res.last  = (remain_q == 8'd1);
          if (remain_q == 8'd1) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      pos_d = pos_q + POS_W'(1);

      // frame or area ends before an answer was given
      if ((frame_last_i || area_end) && phase_d != PH_DONE) begin
        res       = '0;
        res.valid = 1'b1;
        res.last  = 1'b1;
        case (phase_d)
          PH_MAGIC:     res.kind = KIND_BADMAGIC;
          PH_LEN_MATCH: res.kind = KIND_TRUNC;
          PH_VALUE: begin
            res.kind = KIND_TRUNC;
            res.vlen = cur_len_d;
          end
          default:      res.kind = KIND_NOTFOUND;
        endcase
        phase_d = PH_DONE;
      end
    end

    // the last byte of a frame starts the next one fresh
    if (frame_last_i) begin
      phase_d     = PH_MAGIC;
      magic_idx_d = 2'd0;
      magic_ok_d  = 1'b1;
      remain_d    = 8'd0;
      cur_len_d   = 8'd0;
      pos_d       = '0;
    end
  end

  // walker state, advanced once per input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      magic_idx_q <= 2'd0;
      magic_ok_q  <= 1'b1;
      remain_q    <= 8'd0;
      cur_len_q   <= 8'd0;
      pos_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      magic_idx_q <= magic_idx_d;
      magic_ok_q  <= magic_ok_d;
      remain_q    <= remain_d;
      cur_len_q   <= cur_len_d;
      pos_q       <= pos_d;
    end
  end

  assign res_o = res;

endmodule

@@ rtl/dhcp_option_extractor.sv @@
`timescale 1ns / 1ps
// output: a result is registered on the input transfer of the byte that causes it and shows in the next cycle
// input: one byte per cycle while the input is not stalled; the walker state updates once per byte
// the output register is refilled in the cycle it is taken, so input stalls only
// when a held result is itself stalled
// reset: asynchronous active low; clears the walker to the cookie check, wanted
// type to 252 and the output register to empty
module dhcp_option_extractor
  import dhcpx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] opt_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] value_byte_o,
  output logic [7:0] value_length_o,
  output logic       is_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic       in_xfer;
  logic [7:0] wanted_q;
  logic       out_valid_q, out_valid_d;
  dhcpx_res_t out_q;
  dhcpx_res_t res;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WANTED_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wanted_q <= cfg_data_i;
    end
  end

  dhcpx_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_xfer),
    .opt_byte_i   (opt_byte_i),
    .frame_last_i (frame_last_i),
    .wanted_type_i(wanted_q),
    .res_o        (res)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign value_byte_o   = out_q.vbyte;
  assign value_length_o = out_q.vlen;
  assign is_last_o      = out_q.last;

endmodule

@@ rtl/dhcpx_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dhcpx_checker
  import dhcpx_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] opt_byte_i,
  input logic       frame_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] value_byte_o,
  input logic [7:0] value_length_o,
  input logic       is_last_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [7:0] cfg_data_i
);

  logic        in_xfer;
  logic        out_held;
  logic        non_value;
  logic        answer_ok;
  logic [19:0] payload;

  // handshake and payload views of the ports
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign non_value = out_valid_o && (kind_o != KIND_VALUE);
  assign answer_ok = is_last_o && (value_byte_o == 8'd0) && (kind_o <= KIND_TRUNC);
  assign payload   = {kind_o, value_byte_o, value_length_o, is_last_o};

  // a held result keeps its payload
  `ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(payload), "stalled result changed")

  // a result comes only from an input transfer or is one still held
  `ASSERT_CLK(a_out_source, out_valid_o |-> $past(in_xfer || out_held), "result without source")

  // input stalls only behind a stalled result
  `ASSERT_CLK(a_in_stall, in_stall_o |-> out_held, "input stalled without cause")

  // answers other than value bytes close the frame and carry no byte
  `ASSERT_CLK(a_answer, non_value |-> answer_ok, "bad answer result")

endmodule

bind dhcp_option_extractor dhcpx_checker u_dhcpx_checker (.*);
